@@ rtl/xesc_pkg.sv @@
// ----------------------------------------------------------------------------
// xesc_pkg
// Shared types and constants of the XML escape core for UCS-2 code units.
// ----------------------------------------------------------------------------
package xesc_pkg;

  localparam int unsigned UnitW = 16;
  localparam int unsigned CharW = 7;

  // ascii codes used by the escape sequences
  localparam logic [CharW-1:0] CH_AMP  = 7'h26;
  localparam logic [CharW-1:0] CH_HASH = 7'h23;
  localparam logic [CharW-1:0] CH_SEMI = 7'h3B;
  localparam logic [CharW-1:0] CH_LT   = 7'h3C;
  localparam logic [CharW-1:0] CH_GT   = 7'h3E;
  localparam logic [CharW-1:0] CH_A    = 7'h61;
  localparam logic [CharW-1:0] CH_G    = 7'h67;
  localparam logic [CharW-1:0] CH_L    = 7'h6C;
  localparam logic [CharW-1:0] CH_M    = 7'h6D;
  localparam logic [CharW-1:0] CH_P    = 7'h70;
  localparam logic [CharW-1:0] CH_T    = 7'h74;
  localparam logic [CharW-1:0] CH_X    = 7'h78;

  // special code units
  localparam logic [UnitW-1:0] U_TAB  = 16'h0009;
  localparam logic [UnitW-1:0] U_NL   = 16'h000A;
  localparam logic [UnitW-1:0] U_SP   = 16'h0020;
  localparam logic [UnitW-1:0] U_TIL  = 16'h007E;
  localparam logic [UnitW-1:0] U_DEL  = 16'h007F;
  localparam logic [UnitW-1:0] U_CMAX = 16'h001F;
  localparam logic [UnitW-1:0] U_AMP  = 16'h0026;
  localparam logic [UnitW-1:0] U_LT   = 16'h003C;
  localparam logic [UnitW-1:0] U_GT   = 16'h003E;

  // how a code unit is rendered
  typedef enum logic [2:0] {
    KIND_PASS,
    KIND_AMP,
    KIND_LT,
    KIND_GT,
    KIND_HEX
  } xesc_kind_e;

  // classified word handed from front to back
  typedef struct packed {
    xesc_kind_e       kind;
    logic [UnitW-1:0] code;
    logic [1:0]       ndig;     // hex digits minus one
    logic             illegal;
  } xesc_desc_t;

endpackage

@@ rtl/xml_escape_ucs2_units_core.sv @@
// ----------------------------------------------------------------------------
// xml_escape_ucs2_units_core
// XML escaping of UCS-2 code units into ASCII bytes, one byte per word.
// ----------------------------------------------------------------------------
// Each input word is one 16-bit code unit; the core emits 1 to 8 output
// words for it (one ASCII byte each, tlast on the final byte, tuser set on
// every byte of a disallowed control character). The front classifies a
// unit in the cycle it is accepted and queues it; the back produces one
// byte per cycle while the output is not stalled, and a unit has 1 byte for a
// plain character, 4 or 5 for the named entities, 5 to 8 for the hex form.
// The output byte rate of one per cycle sets the throughput while the output is
// not stalled; input is taken every cycle while the QDepth-entry queue has room.
module xml_escape_ucs2_units_core
  import xesc_pkg::*;
#(
  parameter int unsigned QDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [6:0] out_char, [7] zero pad
  output logic        m_axis_tlast,   // last
  output logic        m_axis_tuser    // illegal
);

  xesc_desc_t       front_desc;
  xesc_desc_t       head_desc;
  logic             push, pop, full, empty;
  logic [CharW-1:0] out_char;

  assign s_axis_tready = !full;
  assign push          = s_axis_tvalid && !full;

  // classify
  xesc_front u_front (
    .code_i (s_axis_tdata),
    .desc_o (front_desc)
  );

  // decoupling queue
  xesc_fifo #(
    .Depth (QDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_desc),
    .pop_i   (pop),
    .rdata_o (head_desc),
    .full_o  (full),
    .empty_o (empty)
  );

  // byte generator
  xesc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .desc_i        (head_desc),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_char_o    (out_char),
    .out_last_o    (m_axis_tlast),
    .out_illegal_o (m_axis_tuser)
  );

  assign m_axis_tdata = {1'b0, out_char};

`ifndef ASSERT_OFF
  // finishing a unit always leaves its final byte in the output register
  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (m_axis_tvalid && m_axis_tlast))
    else $error("pop without final byte");

  // the back never retires a unit from an empty queue
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty |-> !pop)
    else $error("pop from empty queue");

  // an illegal unit is always in hex form, closed by a semicolon
  a_illegal_semi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast && m_axis_tuser) |-> (out_char == CH_SEMI))
    else $error("illegal unit not closed by semicolon");
`endif

endmodule

@@ rtl/xesc_front.sv @@
// ----------------------------------------------------------------------------
// xesc_front
// Classifies each incoming code unit into a rendering descriptor.
// ----------------------------------------------------------------------------
module xesc_front
  import xesc_pkg::*;
(
  input  logic [UnitW-1:0] code_i,
  output xesc_desc_t       desc_o
);

  logic       is_pass;
  xesc_kind_e kind;
  logic [1:0] ndig;
  logic       illegal;

  // printable ascii, tab and newline pass through, but for &, < and >
  assign is_pass = (code_i == U_TAB) || (code_i == U_NL) ||
                   ((code_i >= U_SP) && (code_i <= U_TIL));

  // kind selection
  always_comb begin
    priority if (code_i == U_AMP) begin
      kind = KIND_AMP;
    end else if (code_i == U_LT) begin
      kind = KIND_LT;
    end else if (code_i == U_GT) begin
      kind = KIND_GT;
    end else if (is_pass) begin
      kind = KIND_PASS;
    end else begin
      kind = KIND_HEX;
    end
  end

  // number of significant hex digits, minus one
  always_comb begin
    priority if (code_i[15:12] != 4'h0) begin
      ndig = 2'd3;
    end else if (code_i[11:8] != 4'h0) begin
      ndig = 2'd2;
    end else if (code_i[7:4] != 4'h0) begin
      ndig = 2'd1;
    end else begin
      ndig = 2'd0;
    end
  end

  assign illegal = !is_pass && ((code_i <= U_CMAX) || (code_i == U_DEL));

  // descriptor word
  assign desc_o = '{kind: kind, code: code_i, ndig: ndig, illegal: illegal};

endmodule

@@ rtl/xesc_fifo.sv @@
// ----------------------------------------------------------------------------
// xesc_fifo
// Small register queue of descriptors between the front and the back.
// ----------------------------------------------------------------------------
module xesc_fifo
  import xesc_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  xesc_desc_t wdata_i,
  input  logic       pop_i,
  output xesc_desc_t rdata_o,
  output logic       full_o,
  output logic       empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  xesc_desc_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

@@ rtl/xesc_back.sv @@
// ----------------------------------------------------------------------------
// xesc_back
// Walks the head descriptor one byte per cycle, while the output accepts, into the output register.
// ----------------------------------------------------------------------------
module xesc_back
  import xesc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  xesc_desc_t       desc_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CharW-1:0] out_char_o,
  output logic             out_last_o,
  output logic             out_illegal_o
);

  logic [2:0]       idx_q, idx_d;
  logic             vld_q;
  logic [CharW-1:0] char_q;
  logic             last_q, ill_q;

  logic             advance;
  logic [CharW-1:0] ch;
  logic             is_last;
  logic [1:0]       idx_m3;
  logic [1:0]       pos;
  logic [3:0]       nib;
  logic [2:0]       semi_idx;

  assign advance = !empty_i && (!vld_q || out_ready_i);
  assign pop_o   = advance && is_last;

  // hex digit position, most significant first
  assign idx_m3   = idx_q[1:0] - 2'd3;
  assign pos      = desc_i.ndig - idx_m3;
  assign semi_idx = {1'b0, desc_i.ndig} + 3'd4;

  always_comb begin
    unique case (pos)
      2'd0:    nib = desc_i.code[3:0];
      2'd1:    nib = desc_i.code[7:4];
      2'd2:    nib = desc_i.code[11:8];
      default: nib = desc_i.code[15:12];
    endcase
  end

  // byte and end mark for the current index
  always_comb begin
    ch      = desc_i.code[CharW-1:0];
    is_last = 1'b0;
    unique case (desc_i.kind)
      KIND_PASS: begin
        is_last = 1'b1;
      end
      KIND_AMP: begin
        unique case (idx_q)
          3'd0:    ch = CH_AMP;
          3'd1:    ch = CH_A;
          3'd2:    ch = CH_M;
          3'd3:    ch = CH_P;
          default: ch = CH_SEMI;
        endcase
        is_last = (idx_q == 3'd4);
      end
      KIND_LT, KIND_GT: begin
        unique case (idx_q)
          3'd0:    ch = CH_AMP;
          3'd1:    ch = (desc_i.kind == KIND_LT) ? CH_L : CH_G;
          3'd2:    ch = CH_T;
          default: ch = CH_SEMI;
        endcase
        is_last = (idx_q == 3'd3);
      end
      default: begin
        if (idx_q == 3'd0) begin
          ch = CH_AMP;
        end else if (idx_q == 3'd1) begin
          ch = CH_HASH;
        end else if (idx_q == 3'd2) begin
          ch = CH_X;
        end else if (idx_q == semi_idx) begin
          ch = CH_SEMI;
        end else if (nib < 4'd10) begin
          ch = 7'h30 + {3'b000, nib};
        end else begin
          ch = 7'h37 + {3'b000, nib};
        end
        is_last = (idx_q == semi_idx);
      end
    endcase
  end

  // byte index within the current unit
  always_comb begin
    idx_d = idx_q;
    if (advance) begin
      idx_d = is_last ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (advance) begin
        vld_q <= 1'b1;
      end else if (out_ready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      char_q <= ch;
      last_q <= is_last;
      ill_q  <= desc_i.illegal;
    end
  end

  assign out_valid_o   = vld_q;
  assign out_char_o    = char_q;
  assign out_last_o    = last_q;
  assign out_illegal_o = ill_q;

endmodule
